/* hdl/assert_macros.svh */
// assertion helper macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle, checked during reset too
`define ASSERT_NEXT_NORST(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hdl/md5kc_pkg.sv */
// ----------------------------------------------------------------------------
// md5kc_pkg
// types, constants and step functions of the md5 candidate key check core
// ----------------------------------------------------------------------------
`default_nettype none

package md5kc_pkg;

   // number of compression steps run per candidate
   localparam int STEPS_RUN = 63;

   // configuration register indexes
   localparam logic [2:0] CSR_TARGET_A = 3'd0;
   localparam logic [2:0] CSR_TARGET_B = 3'd1;
   localparam logic [2:0] CSR_TARGET_C = 3'd2;
   localparam logic [2:0] CSR_TARGET_D = 3'd3;

   // md5 initial values
   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;

   // round codes
   localparam logic [1:0] ROUND_F = 2'd0;
   localparam logic [1:0] ROUND_G = 2'd1;
   localparam logic [1:0] ROUND_H = 2'd2;
   localparam logic [1:0] ROUND_I = 2'd3;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
   } md5kc_state_type;

   typedef struct packed {
      logic [31:0] word0;
      logic [31:0] word1;
      logic [31:0] word2;
      logic [31:0] word3;
      logic [7:0]  bit_length;
   } md5kc_key_type;

   // additive constant of each step
   function automatic logic [31:0] md5kc_k(input logic [5:0] idx);
      logic [31:0] k;
      case (idx)
         6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   // rotate amount from round and position in the group of four
   function automatic logic [4:0] md5kc_rot(input logic [5:0] idx);
      logic [4:0] s;
      case ({idx[5:4], idx[1:0]})
         4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
         4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
         4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
         4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  default: s = 5'd21;
      endcase
      return s;
   endfunction

   // message word index used by a step
   function automatic logic [3:0] md5kc_msg_idx(input logic [5:0] idx);
      logic [3:0] m;
      case (idx[5:4])
         ROUND_F: m = idx[3:0];
         ROUND_G: m = 4'd1 + 4'd5 * idx[3:0];
         ROUND_H: m = 4'd5 + 4'd3 * idx[3:0];
         default: m = 4'd7 * idx[3:0];
      endcase
      return m;
   endfunction

   // nonlinear function of each round
   function automatic logic [31:0] md5kc_round_fn(input logic [1:0] round,
                                                  input logic [31:0] x,
                                                  input logic [31:0] y,
                                                  input logic [31:0] z);
      logic [31:0] f;
      case (round)
         ROUND_F: f = (x & y) | (~x & z);
         ROUND_G: f = (x & z) | (y & ~z);
         ROUND_H: f = x ^ y ^ z;
         default: f = y ^ (x | ~z);
      endcase
      return f;
   endfunction

   // 32-bit rotate left
   function automatic logic [31:0] md5kc_rotl(input logic [31:0] v, input logic [4:0] s);
      logic [63:0] dbl;
      dbl = {v, v} << s;
      return dbl[63:32];
   endfunction

endpackage

`default_nettype wire

/* hdl/md5kc_if.sv */
// ----------------------------------------------------------------------------
// md5kc_if
// valid/ready channels for candidate requests and check responses
// ----------------------------------------------------------------------------
`default_nettype none

interface md5kc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] word0;
   logic [31:0] word1;
   logic [31:0] word2;
   logic [31:0] word3;
   logic [7:0]  bit_length;

   modport source(output valid, output word0, output word1, output word2,
                  output word3, output bit_length, input ready);
   modport sink(input valid, input word0, input word1, input word2,
                input word3, input bit_length, output ready);
endinterface

interface md5kc_rsp_if;
   logic        valid;
   logic        ready;
   logic        match;
   logic [31:0] key_word0;
   logic [31:0] key_word1;
   logic [31:0] key_word2;
   logic [31:0] key_word3;
   logic [7:0]  key_bits;

   modport source(output valid, output match, output key_word0, output key_word1,
                  output key_word2, output key_word3, output key_bits, input ready);
   modport sink(input valid, input match, input key_word0, input key_word1,
                input key_word2, input key_word3, input key_bits, output ready);
endinterface

`default_nettype wire

/* hdl/md5kc_step.sv */
// ----------------------------------------------------------------------------
// md5kc_step
// one md5 compression step followed by its pipeline register
// ----------------------------------------------------------------------------
`default_nettype none

module md5kc_step (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       advance,
   input  wire logic [5:0]                 step_idx,
   input  wire logic                       valid_in,
   input  wire md5kc_pkg::md5kc_state_type state_in,
   input  wire md5kc_pkg::md5kc_key_type   key_in,
   output logic                            valid_out,
   output md5kc_pkg::md5kc_state_type      state_out,
   output md5kc_pkg::md5kc_key_type        key_out
);
   import md5kc_pkg::*;

   logic            valid_ff;
   md5kc_state_type state_ff, state_in_nx;
   md5kc_key_type   key_ff;
   logic [31:0]     tgt, x, y, z, f, msg, sum, new_word;
   logic [3:0]      m_idx;

   // pick the word being updated and its three neighbors
   always_comb begin
      case (step_idx[1:0])
         2'd0: begin tgt = state_in.a; x = state_in.b; y = state_in.c; z = state_in.d; end
         2'd1: begin tgt = state_in.d; x = state_in.a; y = state_in.b; z = state_in.c; end
         2'd2: begin tgt = state_in.c; x = state_in.d; y = state_in.a; z = state_in.b; end
         default: begin tgt = state_in.b; x = state_in.c; y = state_in.d; z = state_in.a; end
      endcase
   end

   // message word: key words 0 to 3, bit length in word 14, zero elsewhere
   always_comb begin
      m_idx = md5kc_msg_idx(step_idx);
      case (m_idx)
         4'd0:    msg = key_in.word0;
         4'd1:    msg = key_in.word1;
         4'd2:    msg = key_in.word2;
         4'd3:    msg = key_in.word3;
         4'd14:   msg = {24'h0, key_in.bit_length};
         default: msg = 32'h0;
      endcase
   end

   // step arithmetic
   always_comb begin
      f        = md5kc_round_fn(step_idx[5:4], x, y, z);
      sum      = tgt + f + msg + md5kc_k(step_idx);
      new_word = x + md5kc_rotl(sum, md5kc_rot(step_idx));
      state_in_nx = state_in;
      case (step_idx[1:0])
         2'd0:    state_in_nx.a = new_word;
         2'd1:    state_in_nx.d = new_word;
         2'd2:    state_in_nx.c = new_word;
         default: state_in_nx.b = new_word;
      endcase
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (advance) begin
         state_ff <= state_in_nx;
         key_ff   <= key_in;
      end
   end

   assign valid_out = valid_ff;
   assign state_out = state_ff;
   assign key_out   = key_ff;

endmodule

`default_nettype wire

/* hdl/md5kc_compare.sv */
// ----------------------------------------------------------------------------
// md5kc_compare
// final state compare against the targets, doubles as the output register
// ----------------------------------------------------------------------------
`default_nettype none

module md5kc_compare (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       advance,
   input  wire logic                       valid_in,
   input  wire md5kc_pkg::md5kc_state_type state_in,
   input  wire md5kc_pkg::md5kc_key_type   key_in,
   input  wire md5kc_pkg::md5kc_state_type targets,
   output logic                            valid_out,
   output logic                            match_out,
   output md5kc_pkg::md5kc_key_type        key_out
);
   import md5kc_pkg::*;

   logic          valid_ff;
   logic          match_ff, match_in;
   md5kc_key_type key_ff;

   // all four words must hit
   assign match_in = (state_in.b == targets.b) && (state_in.a == targets.a) &&
                     (state_in.d == targets.d) && (state_in.c == targets.c);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         match_ff <= match_in;
         key_ff   <= key_in;
      end
   end

   assign valid_out = valid_ff;
   assign match_out = match_ff;
   assign key_out   = key_ff;

endmodule

`default_nettype wire

/* hdl/md5_single_block_key_check_core.sv */
// ----------------------------------------------------------------------------
// md5_single_block_key_check_core
// pipelined md5 candidate key checker; unless the response stalls, one candidate per clock
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one candidate (four message words and its bit length);
//   rsp_chan returns a match flag with the candidate echoed, one response per
//   request, in order. Targets are loaded over the csr port (index 0 to 3 for
//   a, b, c, d) while no candidate is in flight; other indexes are ignored.
// Stages: 64 register stages, 63 of them one md5 step each, then a compare
//   stage that is also the output register, from which the response is taken.
// Throughput: one candidate per cycle, set by the one-step-per-stage pipeline.
// Stall: the whole pipeline holds while the response waits; req_chan.ready is
//   high whenever the output register is empty or being taken this cycle.
// Reset: synchronous; clears all stage valid bits and the four targets.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_single_block_key_check_core (
   input  wire logic        clock,
   input  wire logic        reset,
   md5kc_req_if.sink        req_chan,
   md5kc_rsp_if.source      rsp_chan,
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wr_data
);
   import md5kc_pkg::*;

   logic            advance;
   logic            stage_valid [0:STEPS_RUN];
   md5kc_state_type stage_state [0:STEPS_RUN];
   md5kc_key_type   stage_key   [0:STEPS_RUN];
   md5kc_state_type targets_ff;
   md5kc_key_type   rsp_key;

   // target registers
   always_ff @(posedge clock) begin
      if (reset) begin
         targets_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TARGET_A: targets_ff.a <= csr_wr_data;
            CSR_TARGET_B: targets_ff.b <= csr_wr_data;
            CSR_TARGET_C: targets_ff.c <= csr_wr_data;
            CSR_TARGET_D: targets_ff.d <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // global pipeline enable
   assign advance        = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = advance;

   // pipeline entry: initial values and the incoming transaction
   assign stage_valid[0]            = req_chan.valid;
   assign stage_state[0]            = '{a: INIT_A, b: INIT_B, c: INIT_C, d: INIT_D};
   assign stage_key[0].word0        = req_chan.word0;
   assign stage_key[0].word1        = req_chan.word1;
   assign stage_key[0].word2        = req_chan.word2;
   assign stage_key[0].word3        = req_chan.word3;
   assign stage_key[0].bit_length   = req_chan.bit_length;

   // one step per stage
   for (genvar g = 0; g < STEPS_RUN; g++) begin : g_step
      md5kc_step u_step (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .step_idx  (6'(g)),
         .valid_in  (stage_valid[g]),
         .state_in  (stage_state[g]),
         .key_in    (stage_key[g]),
         .valid_out (stage_valid[g+1]),
         .state_out (stage_state[g+1]),
         .key_out   (stage_key[g+1])
      );
   end

   // compare and output register
   md5kc_compare u_compare (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .valid_in  (stage_valid[STEPS_RUN]),
      .state_in  (stage_state[STEPS_RUN]),
      .key_in    (stage_key[STEPS_RUN]),
      .targets   (targets_ff),
      .valid_out (rsp_chan.valid),
      .match_out (rsp_chan.match),
      .key_out   (rsp_key)
   );

   assign rsp_chan.key_word0 = rsp_key.word0;
   assign rsp_chan.key_word1 = rsp_key.word1;
   assign rsp_chan.key_word2 = rsp_key.word2;
   assign rsp_chan.key_word3 = rsp_key.word3;
   assign rsp_chan.key_bits  = rsp_key.bit_length;

endmodule

`default_nettype wire

/* hdl/md5kc_checker.sv */
// ----------------------------------------------------------------------------
// md5kc_checker
// port level checks of the candidate key check core, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module md5kc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_match,
   input wire logic [31:0] rsp_key_word0,
   input wire logic [7:0]  rsp_key_bits
);

   logic        rsp_stalled;
   logic        req_fire;
   logic [40:0] rsp_payload;

   assign rsp_stalled = rsp_valid && !rsp_ready;
   assign req_fire    = req_valid && req_ready;
   assign rsp_payload = {rsp_match, rsp_key_word0, rsp_key_bits};

   // response held while stalled
   `ASSERT_NEXT(a_rsp_valid_hold, clock, reset, rsp_stalled, rsp_valid)
   `ASSERT_NEXT(a_rsp_data_hold, clock, reset, rsp_stalled, $stable(rsp_payload))

   // intake open exactly when the output slot is free or draining
   `ASSERT_IMPLY(a_ready_rule, clock, reset, 1'b1, req_ready == (!rsp_valid || rsp_ready))

   // no transaction taken while the output is stuck
   `ASSERT_IMPLY(a_no_take_stalled, clock, reset, rsp_stalled, !req_fire)

   // output register empty right after reset
   `ASSERT_NEXT_NORST(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind md5_single_block_key_check_core md5kc_checker u_md5kc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_match     (rsp_chan.match),
   .rsp_key_word0 (rsp_chan.key_word0),
   .rsp_key_bits  (rsp_chan.key_bits)
);

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5 candidate key check testbench
// drives candidate keys through the pipelined checker and compares every
// response against a behavioral model of the truncated md5 compression; the
// targets are loaded from known keys so that hits, near misses and single
// target mismatches all show up, under random idling and a long output stall
// ----------------------------------------------------------------------------

module testbench;
   import md5kc_pkg::*;

   // unused register indexes, writes there must be ignored
   localparam logic [2:0] CSR_UNUSED_FIRST = 3'd4;
   localparam logic [2:0] CSR_UNUSED_LAST  = 3'd7;

   // cycles without any transaction before the run is declared hung
   localparam int STALL_LIMIT    = 5000;
   // pipeline depth plus margin for the final quiet period
   localparam int DRAIN_CYCLES   = 80;
   localparam int HOLD_OFF_CYCLES = 300;

   // additive constant of each step, step 0 in the top word
   localparam logic [63*32-1:0] STEP_ADD = {
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb
   };

   // rotate amounts by round and position in the group of four
   localparam logic [16*5-1:0] ROT_AMOUNTS = {
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   typedef struct packed {
      logic        match;
      logic [31:0] key_word0;
      logic [31:0] key_word1;
      logic [31:0] key_word2;
      logic [31:0] key_word3;
      logic [7:0]  key_bits;
   } key_verdict_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [31:0] csr_wr_data;

   md5kc_req_if req_chan();
   md5kc_rsp_if rsp_chan();

   md5_single_block_key_check_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // copy of the target registers as the block should hold them
   logic [31:0] target_a_now;
   logic [31:0] target_b_now;
   logic [31:0] target_c_now;
   logic [31:0] target_d_now;

   key_verdict_type pending_verdicts[$];
   int error_count;
   int quiet_cycles;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_left;

   // clock
   always #5 clock = ~clock;

   // state after steps 0 to 62 of the compression for one candidate
   function automatic md5kc_state_type run_md5_steps(input md5kc_key_type key);
      logic [31:0] msg [16];
      logic [31:0] r [4];
      logic [31:0] x, y, z, f, sum;
      logic [5:0]  step;
      logic [1:0]  rnd;
      int          w, m, s;
      md5kc_state_type st;
      for (int j = 0; j < 16; j++) msg[j] = '0;
      msg[0]  = key.word0;
      msg[1]  = key.word1;
      msg[2]  = key.word2;
      msg[3]  = key.word3;
      msg[14] = {24'd0, key.bit_length};
      r[0] = INIT_A;
      r[1] = INIT_B;
      r[2] = INIT_C;
      r[3] = INIT_D;
      for (int i = 0; i < STEPS_RUN; i++) begin
         step = i[5:0];
         rnd  = step[5:4];
         // register updated this step rotates backwards through a, d, c, b
         w = (4 - (i % 4)) % 4;
         x = r[(w + 1) % 4];
         y = r[(w + 2) % 4];
         z = r[(w + 3) % 4];
         case (rnd)
            ROUND_F: begin
               f = (x & y) | (~x & z);
               m = i % 16;
            end
            ROUND_G: begin
               f = (x & z) | (y & ~z);
               m = (1 + 5 * i) % 16;
            end
            ROUND_H: begin
               f = x ^ y ^ z;
               m = (5 + 3 * i) % 16;
            end
            default: begin
               f = y ^ (x | ~z);
               m = (7 * i) % 16;
            end
         endcase
         sum = r[w] + f + msg[m] + STEP_ADD[(62 - i) * 32 +: 32];
         s = ROT_AMOUNTS[(15 - (rnd * 4 + i % 4)) * 5 +: 5];
         r[w] = x + ((sum << s) | (sum >> (32 - s)));
      end
      st.a = r[0];
      st.b = r[1];
      st.c = r[2];
      st.d = r[3];
      return st;
   endfunction

   // expected response for a candidate under the current targets
   function automatic key_verdict_type predict_verdict(input md5kc_key_type key);
      md5kc_state_type st;
      key_verdict_type v;
      st = run_md5_steps(key);
      v.match = (st.b == target_b_now) && (st.a == target_a_now) &&
                (st.d == target_d_now) && (st.c == target_c_now);
      v.key_word0 = key.word0;
      v.key_word1 = key.word1;
      v.key_word2 = key.word2;
      v.key_word3 = key.word3;
      v.key_bits  = key.bit_length;
      return v;
   endfunction

   function automatic logic [31:0] target_for(input md5kc_state_type st,
                                              input logic [2:0] index);
      logic [31:0] t;
      case (index)
         CSR_TARGET_A: t = st.a;
         CSR_TARGET_B: t = st.b;
         CSR_TARGET_C: t = st.c;
         default:      t = st.d;
      endcase
      return t;
   endfunction

   function automatic md5kc_key_type random_candidate();
      md5kc_key_type key;
      key.word0      = $urandom;
      key.word1      = $urandom;
      key.word2      = $urandom;
      key.word3      = $urandom;
      key.bit_length = 8'($urandom_range(255));
      return key;
   endfunction

   // candidate one bit away from the given key
   function automatic md5kc_key_type near_miss(input md5kc_key_type key);
      logic [135:0] flip;
      flip = '0;
      flip[$urandom_range(135)] = 1'b1;
      return key ^ flip;
   endfunction

   task automatic report_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %h, actual %h", name, want, got);
         error_count++;
      end
   endtask

   // response checking, request capture, target tracking and watchdog
   always @(posedge clock) begin : monitor
      key_verdict_type want;
      md5kc_key_type   got_key;
      logic            moved;
      if (!reset) begin
         moved = 1'b0;
         // response transaction against the oldest expectation
         if (rsp_chan.valid && rsp_chan.ready) begin
            moved = 1'b1;
            if (pending_verdicts.size() == 0) begin
               $error("response with none expected: key_word0 %h", rsp_chan.key_word0);
               error_count++;
            end else begin
               want = pending_verdicts.pop_front();
               report_field("match", 32'(want.match), 32'(rsp_chan.match));
               report_field("key_word0", want.key_word0, rsp_chan.key_word0);
               report_field("key_word1", want.key_word1, rsp_chan.key_word1);
               report_field("key_word2", want.key_word2, rsp_chan.key_word2);
               report_field("key_word3", want.key_word3, rsp_chan.key_word3);
               report_field("key_bits", 32'(want.key_bits), 32'(rsp_chan.key_bits));
            end
         end
         // request transaction, predicted with the targets now in force
         if (req_chan.valid && req_chan.ready) begin
            moved = 1'b1;
            got_key.word0      = req_chan.word0;
            got_key.word1      = req_chan.word1;
            got_key.word2      = req_chan.word2;
            got_key.word3      = req_chan.word3;
            got_key.bit_length = req_chan.bit_length;
            pending_verdicts.push_back(predict_verdict(got_key));
         end
         if (csr_wr_en) begin
            moved = 1'b1;
            case (csr_index)
               CSR_TARGET_A: target_a_now = csr_wr_data;
               CSR_TARGET_B: target_b_now = csr_wr_data;
               CSR_TARGET_C: target_c_now = csr_wr_data;
               CSR_TARGET_D: target_d_now = csr_wr_data;
               default: ;
            endcase
         end
         // watchdog
         if (moved) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL md5_single_block_key_check_core");
            $finish;
         end
      end
   end

   // response side: random idling, or a long hold-off when requested
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // one request transaction, entered and left at a falling edge
   task automatic send_candidate(input md5kc_key_type key);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.word0      <= key.word0;
      req_chan.word1      <= key.word1;
      req_chan.word2      <= key.word2;
      req_chan.word3      <= key.word3;
      req_chan.bit_length <= key.bit_length;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   // stop offering and wait until every response is back
   task automatic drain_pipeline();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (pending_verdicts.size() != 0) @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] index, input logic [31:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // program the targets so that this key hits
   task automatic load_targets_for(input md5kc_key_type key);
      md5kc_state_type st;
      st = run_md5_steps(key);
      csr_write(CSR_TARGET_A, st.a);
      csr_write(CSR_TARGET_B, st.b);
      csr_write(CSR_TARGET_C, st.c);
      csr_write(CSR_TARGET_D, st.d);
   endtask

   // targets still at their reset value, field extremes
   task automatic test_reset_targets();
      md5kc_key_type key;
      send_idle_pct = 10;
      recv_idle_pct = 10;
      key = '0;
      send_candidate(key);
      key = '1;
      send_candidate(key);
      key = '{32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555, 8'd128};
      send_candidate(key);
      key = '{32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 8'd127};
      send_candidate(key);
      key = '{32'h00000080, 32'h0, 32'h0, 32'h0, 8'd0};
      send_candidate(key);
      drain_pipeline();
   endtask

   // hit, near misses, each target alone wrong, ignored indexes, all-ones targets
   task automatic test_target_registers();
      md5kc_key_type   secret;
      md5kc_key_type   key;
      md5kc_state_type st;
      secret = '{32'h73736170, 32'h64726f77, 32'h00000080, 32'h0, 8'd64};
      st = run_md5_steps(secret);
      load_targets_for(secret);
      send_candidate(secret);
      key = secret;
      key.bit_length = 8'd72;
      send_candidate(key);
      key = secret;
      key.word3 = 32'h80000000;
      send_candidate(key);
      drain_pipeline();

      // one target off by a bit, the rest right
      for (logic [3:0] idx = CSR_TARGET_A; idx <= CSR_TARGET_D; idx++) begin
         csr_write(idx[2:0], target_for(st, idx[2:0]) ^ 32'h1);
         send_candidate(secret);
         drain_pipeline();
         csr_write(idx[2:0], target_for(st, idx[2:0]));
      end

      // writes to unused indexes leave the targets alone
      for (logic [3:0] idx = CSR_UNUSED_FIRST; idx <= CSR_UNUSED_LAST; idx++)
         csr_write(idx[2:0], 32'hffffffff);
      send_candidate(secret);
      drain_pipeline();

      csr_write(CSR_TARGET_A, 32'hffffffff);
      csr_write(CSR_TARGET_B, 32'hffffffff);
      csr_write(CSR_TARGET_C, 32'hffffffff);
      csr_write(CSR_TARGET_D, 32'hffffffff);
      send_candidate(secret);
      key = '1;
      send_candidate(key);
      drain_pipeline();
   endtask

   // random candidates mixed with hits and near misses of a fresh secret
   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input int rounds, input int per_round);
      md5kc_key_type secret;
      int            pick;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int r = 0; r < rounds; r++) begin
         drain_pipeline();
         secret = random_candidate();
         load_targets_for(secret);
         for (int n = 0; n < per_round; n++) begin
            pick = $urandom_range(99);
            if (pick < 12) send_candidate(secret);
            else if (pick < 24) send_candidate(near_miss(secret));
            else send_candidate(random_candidate());
         end
      end
      drain_pipeline();
   endtask

   // long output stall while requests keep coming, pipeline must fill and hold
   task automatic test_output_stall();
      md5kc_key_type secret;
      secret = random_candidate();
      load_targets_for(secret);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_left = HOLD_OFF_CYCLES;
      for (int n = 0; n < 150; n++) begin
         if (n % 10 == 0) send_candidate(secret);
         else send_candidate(random_candidate());
      end
      drain_pipeline();
   endtask

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_index      = CSR_TARGET_A;
      csr_wr_data    = '0;
      req_chan.valid = 1'b0;
      req_chan.word0 = '0;
      req_chan.word1 = '0;
      req_chan.word2 = '0;
      req_chan.word3 = '0;
      req_chan.bit_length = '0;
      rsp_chan.ready = 1'b0;
      target_a_now   = '0;
      target_b_now   = '0;
      target_c_now   = '0;
      target_d_now   = '0;
      error_count    = 0;
      quiet_cycles   = 0;
      send_idle_pct  = 0;
      recv_idle_pct  = 0;
      hold_left      = 0;

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_targets();
      test_target_registers();
      test_random_traffic(28, 46, 4, 155);
      test_random_traffic(46, 28, 4, 155);
      test_random_traffic(0, 0, 4, 155);
      test_output_stall();

      // quiet period to catch stray responses
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_verdicts.size() == 0)
         $display("PASS md5_single_block_key_check_core");
      else
         $display("FAIL md5_single_block_key_check_core");
      $finish;
   end

endmodule

/* files.f */
+incdir+hdl
hdl/md5kc_pkg.sv
hdl/md5kc_if.sv
hdl/md5kc_step.sv
hdl/md5kc_compare.sv
hdl/md5_single_block_key_check_core.sv
hdl/md5kc_checker.sv
dv/testbench.sv
